### design/triangle_angle_range_check_macros.svh
`ifndef TRIANGLE_ANGLE_RANGE_CHECK_MACROS_SVH
`define TRIANGLE_ANGLE_RANGE_CHECK_MACROS_SVH

`ifndef SYNTH
`define TARC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tarc assertion failed");
`define TARC_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tarc forbidden condition seen");
`else
`define TARC_ASSERT(name, clk, rst, prop)
`define TARC_NEVER(name, clk, rst, cond)
`endif

`endif

### design/tarc_pkg.sv
package tarc_pkg;

   localparam int FIELD_WIDTH = 16;
   localparam int TSQ_WIDTH   = 31;
   localparam int LANE_LAT    = 9;
   localparam int TOTAL_LAT   = LANE_LAT + 1;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_COS_MAX_ANGLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_MIN_ANGLE = 1'b1;

   localparam logic signed [FIELD_WIDTH-1:0] COS_MAX_RESET = -16'sd572;
   localparam logic signed [FIELD_WIDTH-1:0] COS_MIN_RESET = 16'sd23571;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] a_x;
      logic signed [FIELD_WIDTH-1:0] a_y;
      logic signed [FIELD_WIDTH-1:0] a_z;
      logic signed [FIELD_WIDTH-1:0] b_x;
      logic signed [FIELD_WIDTH-1:0] b_y;
      logic signed [FIELD_WIDTH-1:0] b_z;
      logic signed [FIELD_WIDTH-1:0] c_x;
      logic signed [FIELD_WIDTH-1:0] c_y;
      logic signed [FIELD_WIDTH-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic       quality_ok;
      logic [2:0] angle_ok_mask;
      logic       degenerate;
   } rsp_type;

   typedef struct packed {
      logic                 lo_pos;
      logic                 hi_neg;
      logic [TSQ_WIDTH-1:0] lo_sq;
      logic [TSQ_WIDTH-1:0] hi_sq;
   } bound_type;

endpackage

### design/tarc_mul.sv
module tarc_mul #(
   parameter int AW = 8,
   parameter int BW = 8
) (
   input  logic              clock,
   input  logic [AW-1:0]     a,
   input  logic [BW-1:0]     b,
   output logic [AW+BW-1:0]  p
);

   localparam int AL = AW / 2;
   localparam int AH = AW - AL;
   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW;

   logic [AL+BL-1:0] ll_ff, ll_in;
   logic [AL+BH-1:0] lh_ff, lh_in;
   logic [AH+BL-1:0] hl_ff, hl_in;
   logic [AH+BH-1:0] hh_ff, hh_in;
   logic [PW-1:0]    p_ff, p_in;

   always_comb begin
      ll_in = a[AL-1:0] * b[BL-1:0];
      lh_in = a[AL-1:0] * b[BW-1:BL];
      hl_in = a[AW-1:AL] * b[BL-1:0];
      hh_in = a[AW-1:AL] * b[BW-1:BL];
      p_in  = PW'(ll_ff) + (PW'(lh_ff) << BL) + (PW'(hl_ff) << AL)
            + (PW'(hh_ff) << (AL + BL));
   end

   always_ff @(posedge clock) begin
      ll_ff <= ll_in;
      lh_ff <= lh_in;
      hl_ff <= hl_in;
      hh_ff <= hh_in;
      p_ff  <= p_in;
   end

   assign p = p_ff;

endmodule

### design/tarc_lane.sv
module tarc_lane #(
   parameter int CW = 16
) (
   input  logic                 clock,
   input  logic [2:0][CW-1:0]   p,
   input  logic [2:0][CW-1:0]   q,
   input  logic [2:0][CW-1:0]   r,
   input  tarc_pkg::bound_type  bounds,
   output logic                 ok,
   output logic                 zero
);

   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 2;
   localparam int MW = 2 * SW;
   localparam int TW = MW + tarc_pkg::TSQ_WIDTH;

   logic signed [2:0][DW-1:0] du_ff, du_in, dv_ff, dv_in;
   logic signed [2:0][PW-1:0] uu_ff, uu_in, vv_ff, vv_in, uv_ff, uv_in;
   logic [SW-1:0]        len1_ff, len1_in, len2_ff, len2_in;
   logic signed [SW-1:0] dot_ff, dot_in;
   logic [SW-1:0]        dmag_ff, dmag_in, l1_ff, l2_ff;
   logic [4:0]           dneg_ff, dneg_in;
   logic [4:0]           zero_ff, zero_in;
   logic [MW-1:0]        dsq, prod;
   logic [1:0][MW-1:0]   dsq_ff;
   logic [MW-1:0]        dsq_in;
   logic [TW-1:0]        tlo, thi, lhs;
   logic                 lo_fail, hi_fail;
   logic                 ok_ff, ok_in, zo_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         du_in[k] = DW'($signed(q[k])) - DW'($signed(p[k]));
         dv_in[k] = DW'($signed(r[k])) - DW'($signed(p[k]));
         uu_in[k] = $signed(du_ff[k]) * $signed(du_ff[k]);
         vv_in[k] = $signed(dv_ff[k]) * $signed(dv_ff[k]);
         uv_in[k] = $signed(du_ff[k]) * $signed(dv_ff[k]);
      end
      len1_in = SW'($signed(uu_ff[0]) + $signed(uu_ff[1]) + $signed(uu_ff[2]));
      len2_in = SW'($signed(vv_ff[0]) + $signed(vv_ff[1]) + $signed(vv_ff[2]));
      dot_in  = SW'($signed(uv_ff[0]) + $signed(uv_ff[1]) + $signed(uv_ff[2]));
      dmag_in = dot_ff[SW-1] ? SW'(-dot_ff) : SW'(dot_ff);
      dneg_in = {dneg_ff[3:0], dot_ff[SW-1]};
      zero_in = {zero_ff[3:0], (len1_ff == '0) || (len2_ff == '0)};
      dsq_in  = dsq;
      lhs     = TW'(dsq_ff[1]) << 30;
      if (dneg_ff[4]) begin
         lo_fail = bounds.lo_pos || (lhs > tlo);
         hi_fail = bounds.hi_neg && (lhs < thi);
      end else begin
         lo_fail = bounds.lo_pos && (lhs < tlo);
         hi_fail = bounds.hi_neg || (lhs > thi);
      end
      ok_in = !zero_ff[4] && !lo_fail && !hi_fail;
   end

   always_ff @(posedge clock) begin
      du_ff   <= du_in;
      dv_ff   <= dv_in;
      uu_ff   <= uu_in;
      vv_ff   <= vv_in;
      uv_ff   <= uv_in;
      len1_ff <= len1_in;
      len2_ff <= len2_in;
      dot_ff  <= dot_in;
      dmag_ff <= dmag_in;
      l1_ff   <= len1_ff;
      l2_ff   <= len2_ff;
      dneg_ff <= dneg_in;
      zero_ff <= zero_in;
      dsq_ff  <= {dsq_ff[0], dsq_in};
      ok_ff   <= ok_in;
      zo_ff   <= zero_ff[4];
   end

   tarc_mul #(.AW(SW), .BW(SW)) u_dsq (
      .clock (clock), .a (dmag_ff), .b (dmag_ff), .p (dsq)
   );

   tarc_mul #(.AW(SW), .BW(SW)) u_prod (
      .clock (clock), .a (l1_ff), .b (l2_ff), .p (prod)
   );

   tarc_mul #(.AW(MW), .BW(tarc_pkg::TSQ_WIDTH)) u_tlo (
      .clock (clock), .a (prod), .b (bounds.lo_sq), .p (tlo)
   );

   tarc_mul #(.AW(MW), .BW(tarc_pkg::TSQ_WIDTH)) u_thi (
      .clock (clock), .a (prod), .b (bounds.hi_sq), .p (thi)
   );

   assign ok   = ok_ff;
   assign zero = zo_ff;

endmodule

### design/triangle_angle_range_check.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_start & !busy       req_data (req_type)
// rsp_      out        rsp_valid, one cycle    rsp_data (rsp_type)
// csr_      in         csr_valid & csr_ready   csr_index, csr_data
//
// One triangle is accepted every cycle while busy is low; its result is
// registered through the three corner lanes (difference, products, sums,
// magnitude, two split multiplier stages, compare) and the merge register.
// Reset is synchronous; busy is high for one cycle after reset, then low.
// The receiver cannot stall: results are never held back.
`include "triangle_angle_range_check_macros.svh"

module triangle_angle_range_check #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_start,
   input  tarc_pkg::req_type                 req_data,
   output logic                              busy,
   output logic                              rsp_valid,
   output tarc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tarc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tarc_pkg::FIELD_WIDTH-1:0]  csr_data
);

   localparam int CW = (COORD_WIDTH < tarc_pkg::FIELD_WIDTH) ?
                       COORD_WIDTH : tarc_pkg::FIELD_WIDTH;
   localparam int FW = tarc_pkg::FIELD_WIDTH;

   logic signed [FW-1:0] cos_max_ff, cos_max_in, cos_min_ff, cos_min_in;
   tarc_pkg::bound_type  bounds_ff, bounds_in;
   logic [FW:0]          mag_lo, mag_hi;
   logic [2:0][CW-1:0]   va, vb, vc;
   logic [2:0]           lane_ok, lane_zero;
   logic [tarc_pkg::LANE_LAT-1:0] vld_ff, vld_in;
   logic                 busy_ff;
   logic                 rsp_valid_ff;
   tarc_pkg::rsp_type    rsp_ff, rsp_in;

   always_comb begin
      cos_max_in = cos_max_ff;
      cos_min_in = cos_min_ff;
      if (csr_valid) begin
         case (csr_index)
            tarc_pkg::CSR_COS_MAX_ANGLE: cos_max_in = csr_data;
            tarc_pkg::CSR_COS_MIN_ANGLE: cos_min_in = csr_data;
            default: ;
         endcase
      end
      mag_lo = cos_max_ff[FW-1] ? (FW+1)'(-cos_max_ff) : (FW+1)'(cos_max_ff);
      mag_hi = cos_min_ff[FW-1] ? (FW+1)'(-cos_min_ff) : (FW+1)'(cos_min_ff);
      bounds_in.lo_pos = !cos_max_ff[FW-1] && (cos_max_ff != '0);
      bounds_in.hi_neg = cos_min_ff[FW-1];
      bounds_in.lo_sq  = tarc_pkg::TSQ_WIDTH'(mag_lo * mag_lo);
      bounds_in.hi_sq  = tarc_pkg::TSQ_WIDTH'(mag_hi * mag_hi);

      va = {req_data.a_z[CW-1:0], req_data.a_y[CW-1:0], req_data.a_x[CW-1:0]};
      vb = {req_data.b_z[CW-1:0], req_data.b_y[CW-1:0], req_data.b_x[CW-1:0]};
      vc = {req_data.c_z[CW-1:0], req_data.c_y[CW-1:0], req_data.c_x[CW-1:0]};

      vld_in = {vld_ff[tarc_pkg::LANE_LAT-2:0], req_start && !busy_ff};

      rsp_in.angle_ok_mask = lane_ok;
      rsp_in.degenerate    = |lane_zero;
      rsp_in.quality_ok    = (lane_ok == 3'b111) && !(|lane_zero);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_max_ff   <= tarc_pkg::COS_MAX_RESET;
         cos_min_ff   <= tarc_pkg::COS_MIN_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cos_max_ff   <= cos_max_in;
         cos_min_ff   <= cos_min_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[tarc_pkg::LANE_LAT-1];
      end
      busy_ff   <= reset;
      bounds_ff <= bounds_in;
      rsp_ff    <= rsp_in;
   end

   tarc_lane #(.CW(CW)) u_lane_a (
      .clock (clock), .p (va), .q (vb), .r (vc), .bounds (bounds_ff),
      .ok (lane_ok[0]), .zero (lane_zero[0])
   );

   tarc_lane #(.CW(CW)) u_lane_b (
      .clock (clock), .p (vb), .q (va), .r (vc), .bounds (bounds_ff),
      .ok (lane_ok[1]), .zero (lane_zero[1])
   );

   tarc_lane #(.CW(CW)) u_lane_c (
      .clock (clock), .p (vc), .q (va), .r (vb), .bounds (bounds_ff),
      .ok (lane_ok[2]), .zero (lane_zero[2])
   );

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TARC_ASSERT(a_result_follows, clock, reset, (req_start && !busy) |-> ##10 rsp_valid)
   `TARC_ASSERT(a_no_spurious, clock, reset, rsp_valid |-> $past(req_start && !busy, 10))
   `TARC_NEVER(a_degen_ok, clock, reset, rsp_valid && rsp_data.degenerate && rsp_data.quality_ok)

endmodule
